[hw/rtl/cubic_bezier_point_generator_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent checks of the Bezier point generator.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_POINT_GENERATOR_UNIT_MACROS_SVH
`define CUBIC_BEZIER_POINT_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define CBPG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBPG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cbpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpg_pkg
// Widths, types and sequencer codes shared by the Bezier point generator.
// ----------------------------------------------------------------------------
package cbpg_pkg;

    localparam int STEPS_LOG2 = 11;
    localparam int STEPS      = 1 << STEPS_LOG2;

    localparam int K_W      = STEPS_LOG2;
    localparam int R_W      = K_W + 1;
    localparam int RR_W     = 2 * K_W + 1;
    localparam int BASIS_W  = 3 * K_W + 1;
    localparam int SHIFT    = 3 * K_W;
    localparam int COORD_W  = 16;
    localparam int MUL_B_W  = COORD_W + 1;
    localparam int PROD_W   = BASIS_W + 1 + MUL_B_W;
    localparam int ACC_W    = 3 * K_W + COORD_W + 1;
    localparam int WSUM_W   = BASIS_W + 2;

    localparam logic [ACC_W-1:0]   DIV_BIAS  = ACC_W'({SHIFT{1'b1}});
    localparam logic [WSUM_W-1:0]  WSUM_FULL = WSUM_W'(1) << SHIFT;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 2 * COORD_W;

    localparam int NUM_REGS   = 8;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_CTRL_X0 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CTRL_X1 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CTRL_X2 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CTRL_X3 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CTRL_Y0 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CTRL_Y1 = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_CTRL_Y2 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_CTRL_Y3 = 3'd7;

    localparam int STEP_W = 4;

    // multiplier operations, one issued per sequencer step
    localparam logic [STEP_W-1:0] OP_RR = 4'd0;
    localparam logic [STEP_W-1:0] OP_KK = 4'd1;
    localparam logic [STEP_W-1:0] OP_B0 = 4'd2;
    localparam logic [STEP_W-1:0] OP_B1 = 4'd3;
    localparam logic [STEP_W-1:0] OP_B2 = 4'd4;
    localparam logic [STEP_W-1:0] OP_B3 = 4'd5;
    localparam logic [STEP_W-1:0] OP_X0 = 4'd6;
    localparam logic [STEP_W-1:0] OP_Y0 = 4'd7;
    localparam logic [STEP_W-1:0] OP_X1 = 4'd8;
    localparam logic [STEP_W-1:0] OP_Y1 = 4'd9;
    localparam logic [STEP_W-1:0] OP_X2 = 4'd10;
    localparam logic [STEP_W-1:0] OP_Y2 = 4'd11;
    localparam logic [STEP_W-1:0] OP_X3 = 4'd12;
    localparam logic [STEP_W-1:0] OP_Y3 = 4'd13;
    localparam logic [STEP_W-1:0] STEP_LAST = 4'd14;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [K_W-1:0] k;
        logic           last;
    } step_item_t;

    typedef struct packed {
        logic idle;
        logic pop;
        logic weight_chk;
        logic weight_ok;
    } back_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_EMIT = 3'b100
    } back_state_t;

endpackage

[hw/rtl/cbpg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpg_front
// Takes tick transactions, applies restart and tracks the curve step.
// ----------------------------------------------------------------------------
module cbpg_front import cbpg_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       restart,
    output logic       item_valid,
    input  logic       item_ready,
    output step_item_t item
);

    logic [K_W-1:0] step_reg;
    logic [K_W-1:0] step_next;
    logic [K_W-1:0] k_sel;

    assign k_sel      = restart ? '0 : step_reg;
    assign step_next  = k_sel + K_W'(1);
    assign item.k     = k_sel;
    assign item.last  = (k_sel == K_W'(STEPS - 1));
    assign item_valid = in_valid;
    assign in_ready   = item_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (in_valid && item_ready) begin
            step_reg <= step_next;
        end
    end

endmodule

[hw/rtl/cbpg_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpg_queue
// Two-entry FIFO between the step tracker and the arithmetic sequencer.
// ----------------------------------------------------------------------------
module cbpg_queue import cbpg_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  step_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output step_item_t out_item
);

    step_item_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[hw/rtl/cbpg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpg_back
// Evaluates the Bernstein sum for one step through a shared multiplier,
// divides by STEPS cubed toward zero and holds the point for the output.
// ----------------------------------------------------------------------------
module cbpg_back import cbpg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  coord_t [NUM_REGS-1:0] ctrl,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  step_item_t            item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output coord_t                point_x,
    output coord_t                point_y,
    output logic                  last_point,
    output back_stat_t            stat
);

    back_state_t state_reg;
    back_state_t state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] wb_op;
    logic              out_valid_reg;
    logic              emit_load;
    logic              pop;

    logic [K_W-1:0]     k_reg;
    logic [R_W-1:0]     r_reg;
    logic               last_reg;
    logic [RR_W-1:0]    rr_reg;
    logic [RR_W-1:0]    kk_reg;
    logic [BASIS_W-1:0] b0_reg;
    logic [BASIS_W-1:0] b1_reg;
    logic [BASIS_W-1:0] b2_reg;
    logic [BASIS_W-1:0] b3_reg;
    logic signed [ACC_W-1:0]  acc_x_reg;
    logic signed [ACC_W-1:0]  acc_y_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    coord_t point_x_reg;
    coord_t point_y_reg;
    logic   last_out_reg;

    logic [BASIS_W-1:0]       mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [BASIS_W-1:0]       prod_lo;
    logic [BASIS_W-1:0]       prod_x3;
    logic [ACC_W-1:0]         bias_x;
    logic [ACC_W-1:0]         bias_y;
    logic [WSUM_W-1:0]        weight_sum;

    assign pop        = (state_reg == ST_IDLE) && item_valid;
    assign item_ready = (state_reg == ST_IDLE);
    assign emit_load  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign wb_op      = step_reg - STEP_W'(1);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            OP_RR: begin mul_a = BASIS_W'(r_reg);  mul_b = MUL_B_W'(r_reg); end
            OP_KK: begin mul_a = BASIS_W'(k_reg);  mul_b = MUL_B_W'(k_reg); end
            OP_B0: begin mul_a = BASIS_W'(rr_reg); mul_b = MUL_B_W'(r_reg); end
            OP_B1: begin mul_a = BASIS_W'(rr_reg); mul_b = MUL_B_W'(k_reg); end
            OP_B2: begin mul_a = BASIS_W'(kk_reg); mul_b = MUL_B_W'(r_reg); end
            OP_B3: begin mul_a = BASIS_W'(kk_reg); mul_b = MUL_B_W'(k_reg); end
            OP_X0: begin mul_a = b0_reg; mul_b = MUL_B_W'(ctrl[REG_CTRL_X0]); end
            OP_Y0: begin mul_a = b0_reg; mul_b = MUL_B_W'(ctrl[REG_CTRL_Y0]); end
            OP_X1: begin mul_a = b1_reg; mul_b = MUL_B_W'(ctrl[REG_CTRL_X1]); end
            OP_Y1: begin mul_a = b1_reg; mul_b = MUL_B_W'(ctrl[REG_CTRL_Y1]); end
            OP_X2: begin mul_a = b2_reg; mul_b = MUL_B_W'(ctrl[REG_CTRL_X2]); end
            OP_Y2: begin mul_a = b2_reg; mul_b = MUL_B_W'(ctrl[REG_CTRL_Y2]); end
            OP_X3: begin mul_a = b3_reg; mul_b = MUL_B_W'(ctrl[REG_CTRL_X3]); end
            OP_Y3: begin mul_a = b3_reg; mul_b = MUL_B_W'(ctrl[REG_CTRL_Y3]); end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(signed'({1'b0, mul_a})) * PROD_W'(mul_b);
    assign prod_lo   = prod_reg[BASIS_W-1:0];
    assign prod_x3   = {prod_lo[BASIS_W-2:0], 1'b0} + prod_lo;

    // truncation toward zero: bias negative sums before the shift
    assign bias_x = acc_x_reg + (acc_x_reg[ACC_W-1] ? DIV_BIAS : '0);
    assign bias_y = acc_y_reg + (acc_y_reg[ACC_W-1] ? DIV_BIAS : '0);

    assign weight_sum = WSUM_W'(b0_reg) + WSUM_W'(b1_reg) + WSUM_W'(b2_reg)
                      + WSUM_W'(b3_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (step_reg == STEP_LAST) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop) begin
                step_reg <= '0;
            end else if (state_reg == ST_CALC) begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (emit_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (pop) begin
            k_reg    <= item.k;
            r_reg    <= R_W'(STEPS) - R_W'(item.k);
            last_reg <= item.last;
        end
        if (state_reg == ST_CALC) begin
            case (wb_op)
                OP_RR: rr_reg <= prod_reg[RR_W-1:0];
                OP_KK: kk_reg <= prod_reg[RR_W-1:0];
                OP_B0: b0_reg <= prod_lo;
                OP_B1: b1_reg <= prod_x3;
                OP_B2: b2_reg <= prod_x3;
                OP_B3: b3_reg <= prod_lo;
                OP_X0: acc_x_reg <= prod_reg[ACC_W-1:0];
                OP_Y0: acc_y_reg <= prod_reg[ACC_W-1:0];
                OP_X1, OP_X2, OP_X3: acc_x_reg <= acc_x_reg + prod_reg[ACC_W-1:0];
                OP_Y1, OP_Y2, OP_Y3: acc_y_reg <= acc_y_reg + prod_reg[ACC_W-1:0];
                default: ;
            endcase
        end
        if (emit_load) begin
            point_x_reg  <= bias_x[SHIFT+COORD_W-1:SHIFT];
            point_y_reg  <= bias_y[SHIFT+COORD_W-1:SHIFT];
            last_out_reg <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign point_x    = point_x_reg;
    assign point_y    = point_y_reg;
    assign last_point = last_out_reg;

    assign stat.idle       = (state_reg == ST_IDLE);
    assign stat.pop        = pop;
    assign stat.weight_chk = (state_reg == ST_CALC) && (step_reg == OP_Y0);
    assign stat.weight_ok  = (weight_sum == WSUM_FULL);

endmodule

[hw/rtl/cubic_bezier_point_generator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_point_generator_unit
// Emits one point of a cubic Bezier curve per tick, stepping t = k/STEPS.
// ----------------------------------------------------------------------------
//  Channel   Ports            Payload
//  tick in   s_axis_*         tdata[0] restart
//  point out m_axis_*         tdata[15:0] x, tdata[31:16] y, tlast last point
//  config    cfg_we/addr/wdata  control point coordinates, index 0..7
//
//  In the sequencer a point is taken from the queue, then passes 15 steps
//  through the single 34x17 multiplier (basis terms, then eight products)
//  and is rounded toward zero into the output register.
//  Ticks are taken at one per cycle until the two-entry queue fills.
//  aresetn is synchronous; it clears the step, the queue, the sequencer state
//  and the control-point registers. The output register holds a point under
//  m_axis_tready low; the sequencer waits in its last state only until that register frees.
// ----------------------------------------------------------------------------
`include "cubic_bezier_point_generator_unit_macros.svh"

module cubic_bezier_point_generator_unit import cbpg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [0] restart
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [15:0] point_x, [31:16] point_y
    output logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COORD_W-1:0]    cfg_wdata
);

    coord_t [NUM_REGS-1:0] ctrl_reg;

    step_item_t front_item;
    logic       front_valid;
    logic       front_ready;
    step_item_t q_item;
    logic       q_valid;
    logic       q_ready;
    coord_t     point_x;
    coord_t     point_y;
    back_stat_t back_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (cfg_we) begin
            ctrl_reg[cfg_addr] <= coord_t'(cfg_wdata);
        end
    end

    cbpg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .restart    (s_axis_tdata[0]),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    cbpg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    cbpg_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl_reg),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (m_axis_tlast),
        .stat       (back_stat)
    );

    assign m_axis_tdata = {point_y, point_x};

    `CBPG_ASSERT_IMP(a_weight_sum, aclk, aresetn, back_stat.weight_chk, back_stat.weight_ok, "basis weights do not sum to STEPS cubed")
    `CBPG_ASSERT_IMP(a_out_from_seq, aclk, aresetn, $rose(m_axis_tvalid), $past(!back_stat.idle), "point shown without a busy sequencer")
    `CBPG_ASSERT_NXT(a_pop_starts, aclk, aresetn, back_stat.pop, !back_stat.idle, "sequencer did not start on a popped step")

endmodule

[dv/cubic_bezier_point_generator_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_point_generator_unit_tb
// Drives ticks into the Bezier point generator under random stalls on both
// sides and checks every point against an exact integer Bernstein sum.
// The runs cover extreme and random control points, random restarts and a
// long output hold-off.
// ----------------------------------------------------------------------------
module cubic_bezier_point_generator_unit_tb;
    import cbpg_pkg::*;

    localparam int     HOLD_CYCLES = 300;
    localparam int     DRAIN_CYCLES = 40;
    localparam longint CYCLE_LIMIT = 1_000_000;
    localparam coord_t MAX_C = 16'sh7FFF;
    localparam coord_t MIN_C = 16'sh8000;

    localparam logic [CFG_ADDR_W-1:0] REG_ORDER [NUM_REGS] = '{
        REG_CTRL_X0, REG_CTRL_X1, REG_CTRL_X2, REG_CTRL_X3,
        REG_CTRL_Y0, REG_CTRL_Y1, REG_CTRL_Y2, REG_CTRL_Y3
    };

    typedef struct {
        coord_t x;
        coord_t y;
        logic   is_last;
    } point_t;

    class curve_point_tracker;
        coord_t         coords [NUM_REGS];
        logic [K_W-1:0] step_k;
        point_t         pending_points [$];
        int             errors;

        function new();
            foreach (coords[i]) coords[i] = '0;
            step_k = '0;
            errors = 0;
        endfunction

        function void set_coord(logic [CFG_ADDR_W-1:0] addr, coord_t value);
            coords[addr] = value;
        endfunction

        function int pending();
            return pending_points.size();
        endfunction

        // exact weighted sum, signed division truncates toward zero
        function longint bernstein_sum(coord_t p0, coord_t p1, coord_t p2, coord_t p3,
                                       longint k);
            longint r;
            longint den;
            r   = longint'(STEPS) - k;
            den = longint'(STEPS) * STEPS * STEPS;
            return (r * r * r * p0 + 3 * k * r * r * p1 + 3 * k * k * r * p2
                    + k * k * k * p3) / den;
        endfunction

        function void note_tick(bit restart);
            point_t p;
            if (restart) step_k = '0;
            p.x = coord_t'(bernstein_sum(coords[REG_CTRL_X0], coords[REG_CTRL_X1],
                                         coords[REG_CTRL_X2], coords[REG_CTRL_X3],
                                         longint'(step_k)));
            p.y = coord_t'(bernstein_sum(coords[REG_CTRL_Y0], coords[REG_CTRL_Y1],
                                         coords[REG_CTRL_Y2], coords[REG_CTRL_Y3],
                                         longint'(step_k)));
            p.is_last = (step_k == K_W'(STEPS - 1));
            step_k = step_k + 1'b1;
            pending_points.push_back(p);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] point mismatch: %s", $time, msg);
        endtask

        task check_point(logic [M_TDATA_W-1:0] data, logic is_last);
            point_t exp_p;
            coord_t got_x;
            coord_t got_y;
            got_x = coord_t'(data[COORD_W-1:0]);
            got_y = coord_t'(data[2*COORD_W-1:COORD_W]);
            if (pending_points.size() == 0) begin
                report($sformatf("unexpected point x=%0d y=%0d", got_x, got_y));
                return;
            end
            exp_p = pending_points.pop_front();
            if (got_x !== exp_p.x)
                report($sformatf("x got %0d exp %0d", got_x, exp_p.x));
            if (got_y !== exp_p.y)
                report($sformatf("y got %0d exp %0d", got_y, exp_p.y));
            if (is_last !== exp_p.is_last)
                report($sformatf("last got %b exp %b", is_last, exp_p.is_last));
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // [0] restart
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // [15:0] point_x, [31:16] point_y
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [COORD_W-1:0]    cfg_wdata;

    logic   quiet = 1'b0;
    logic   hold_pending = 1'b0;
    longint cycle_count = 0;

    curve_point_tracker tracker;

    cubic_bezier_point_generator_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // transaction monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) tracker.note_tick(s_axis_tdata[0]);
            if (m_axis_tvalid && m_axis_tready) tracker.check_point(m_axis_tdata, m_axis_tlast);
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending  <= 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_axis_tready <= quiet || ($urandom_range(99) >= 9);
        end
    end

    function automatic coord_t rand_coord();
        case ($urandom_range(3))
            0:       return MIN_C;
            1:       return MAX_C;
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic program_curve(input coord_t pts [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= REG_ORDER[i];
            cfg_wdata <= pts[i];
            @(posedge aclk);
            tracker.set_coord(REG_ORDER[i], pts[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_tick(input bit restart);
        while (!quiet && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-1){1'b0}}, restart};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // odds 0: restart on the first tick only
    task automatic run_ticks(input int count, input int odds);
        bit restart;
        for (int i = 0; i < count; i++) begin
            if (odds == 0) restart = (i == 0);
            else restart = ($urandom_range(odds - 1) == 0);
            send_tick(restart);
        end
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    initial begin
        coord_t pts [NUM_REGS];
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        tracker = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset registers, extremes, truncation of small negatives
        run_ticks(3, 0);
        program_curve('{MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C});
        run_ticks(5, 0);
        program_curve('{MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C});
        run_ticks(5, 0);
        program_curve('{MIN_C, MAX_C, MIN_C, MAX_C, MAX_C, MIN_C, MAX_C, MIN_C});
        run_ticks(5, 0);
        program_curve('{16'sd0, 16'sd0, 16'sd0, -16'sd1, -16'sd5, 16'sd7, -16'sd3, 16'sd2});
        run_ticks(5, 0);

        // random curves and restart rates; one quiet phase, one long hold-off
        for (int ph = 0; ph < 6; ph++) begin
            foreach (pts[i]) pts[i] = rand_coord();
            quiet <= (ph == 2);
            if (ph == 3) hold_pending <= 1'b1;
            program_curve(pts);
            run_ticks(220, $urandom_range(2, 300));
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
